>>> design/rwt_pkg.sv
`default_nettype none
package rwt_pkg;

	// Operation codes of a request.
	typedef enum logic [1:0] {
		OP_CHECK = 2'd0,
		OP_ADD   = 2'd1,
		OP_FREE  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DIFF,
		ST_MAG,
		ST_UPDATE,
		ST_ADD,
		ST_DONE
	} state_t;

	// Word address of the forward window limit register.
	localparam logic REG_FWD_LIMIT = 1'b0;
	localparam logic [31:0] FWD_LIMIT_RESET = 32'd32;

	localparam int unsigned KEY_BYTES = 8;
	localparam logic [3:0] KEY_BYTES_MAX = 4'd8;

	// One stored client record, without its window.
	typedef struct packed {
		logic [63:0] key;
		logic [3:0]  klen;
		logic [63:0] ctx;
		logic [3:0]  clen;
		logic [39:0] seq;
		logic [31:0] stamp;
	} rec_t;

	// Outcome of comparing one record with the request.
	typedef struct packed {
		logic hit;
		logic clear;
		logic older;
	} match_t;

	// Lengths above eight bytes count as eight.
	function automatic logic [3:0] clamp_len(input logic [3:0] len);
		clamp_len = (len > KEY_BYTES_MAX) ? KEY_BYTES_MAX : len;
	endfunction

	// Mask that keeps the first len bytes of a left-aligned byte string.
	function automatic logic [63:0] byte_mask(input logic [3:0] len);
		logic [63:0] m;
		m = '0;
		for (int b = 0; b < KEY_BYTES; b++) begin
			if (4'(b) < len) begin
				m[63 - 8*b -: 8] = 8'hFF;
			end
		end
		byte_mask = m;
	endfunction

endpackage
`default_nettype wire

>>> design/replay_window_table.sv
// Channel   | Valid      | Ready      | Payload
// ----------+------------+------------+------------------------------------------
// request   | in_valid   | in_ready   | operation, sequence_number, key_id, ...
// result    | out_valid  | out_ready  | accepted, found
// config    | psel       | pready     | paddr, pwdata (write), prdata (read)
//
// Each request scans all RECORDS records through one compare unit, one record
// per cycle behind the registered memory read. The request side is ready only
// between requests; the result register lets a new request start while the
// previous result is still waiting.
// Reset empties the table at once through the valid flip-flops.
`default_nettype none
module replay_window_table #(
	parameter int RECORDS     = 16,
	parameter int WINDOW_BITS = 32
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	output logic       in_ready,
	input  wire [1:0]  operation,
	input  wire [39:0] sequence_number,
	input  wire [63:0] key_id,
	input  wire [3:0]  key_id_length,
	input  wire [63:0] context_id,
	input  wire [3:0]  context_length,
	input  wire [31:0] now,
	output logic       out_valid,
	input  wire        out_ready,
	output logic       accepted,
	output logic       found,
	input  wire        psel,
	input  wire        penable,
	input  wire        pwrite,
	input  wire [2:0]  paddr,
	input  wire [31:0] pwdata,
	output logic [31:0] prdata,
	output logic       pready
);

	localparam int IW = (RECORDS > 1) ? $clog2(RECORDS) : 1;
	localparam int CW = $clog2(RECORDS + 1);
	localparam int SW = $clog2(WINDOW_BITS);
	localparam logic [CW-1:0] LAST = CW'(RECORDS);
	localparam logic [WINDOW_BITS-1:0] WIN_ONE = WINDOW_BITS'(1);

	rwt_pkg::state_t state_q, state_d;

	logic [31:0] limit_q;

	// Latched request, with lengths clamped and unused bytes zeroed.
	rwt_pkg::op_t op_q;
	logic [39:0]  seq_q;
	logic [63:0]  key_q;
	logic [3:0]   klen_q;
	logic [63:0]  ctx_q;
	logic [3:0]   clen_q;
	logic [31:0]  now_q;

	// Scan pipeline and accumulators.
	logic [CW-1:0]          addr_q;
	logic                   pv_s1;
	logic [IW-1:0]          pidx_s1;
	logic                   hit_q;
	logic [IW-1:0]          hit_idx_q;
	logic [39:0]            hit_seq_q;
	logic [WINDOW_BITS-1:0] hit_win_q;
	logic                   empty_seen_q;
	logic [IW-1:0]          empty_idx_q;
	logic [IW-1:0]          old_idx_q;
	logic [31:0]            old_stamp_q;
	logic                   freed_q;

	// Window arithmetic.
	logic [40:0] diff_q;
	logic [39:0] dist_q;
	logic        older_q;

	logic res_acc_q;
	logic res_found_q;
	logic out_valid_q;
	logic accepted_q;
	logic found_q;

	rwt_pkg::rec_t          rd_rec;
	logic [WINDOW_BITS-1:0] rd_win;
	logic                   rd_valid;
	rwt_pkg::match_t        m;

	logic                   wr_en;
	logic [IW-1:0]          wr_addr;
	rwt_pkg::rec_t          wr_rec;
	logic [WINDOW_BITS-1:0] wr_win;
	logic                   set_en;
	logic                   clr_en;

	logic                   scan_end;
	logic                   in_win;
	logic [SW-1:0]          sh;
	logic                   acc_c;
	logic [WINDOW_BITS-1:0] win_c;
	logic [39:0]            seq_c;
	logic                   load_out;
	logic                   in_fire;
	logic                   cfg_wr;

	rwt_store #(
		.RECORDS     (RECORDS),
		.WINDOW_BITS (WINDOW_BITS),
		.IW          (IW)
	) u_store (
		.clk        (clk),
		.arst_n     (arst_n),
		.rd_addr    (addr_q[IW-1:0]),
		.rd_rec_q   (rd_rec),
		.rd_win_q   (rd_win),
		.rd_valid_q (rd_valid),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_rec     (wr_rec),
		.wr_win     (wr_win),
		.set_en     (set_en),
		.clr_en     (clr_en),
		.clr_addr   (pidx_s1)
	);

	rwt_match u_match (
		.op        (op_q),
		.key       (key_q),
		.klen      (klen_q),
		.ctx       (ctx_q),
		.clen      (clen_q),
		.rec       (rd_rec),
		.rec_valid (rd_valid),
		.old_stamp (old_stamp_q),
		.m         (m)
	);

	// Configuration port.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= rwt_pkg::FWD_LIMIT_RESET;
		end else if (cfg_wr && (paddr[2] == rwt_pkg::REG_FWD_LIMIT)) begin
			limit_q <= pwdata;
		end
	end

	always_comb begin
		prdata = (paddr[2] == rwt_pkg::REG_FWD_LIMIT) ? limit_q : 32'd0;
	end

	// Check decision on the matched record.
	always_comb begin
		in_win = dist_q < 40'(WINDOW_BITS);
		sh     = dist_q[SW-1:0];
		if (older_q) begin
			acc_c = in_win && !hit_win_q[sh];
			win_c = acc_c ? (hit_win_q | (WIN_ONE << sh)) : hit_win_q;
			seq_c = hit_seq_q;
		end else begin
			acc_c = dist_q <= {8'd0, limit_q};
			win_c = acc_c ? ((in_win ? (hit_win_q << sh) : '0) | WIN_ONE) : hit_win_q;
			seq_c = acc_c ? seq_q : hit_seq_q;
		end
	end

	// Sequencer: next state and store write controls.
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		wr_en    = 1'b0;
		set_en   = 1'b0;
		wr_addr  = hit_idx_q;
		wr_win   = win_c;
		wr_rec   = '{key: key_q, klen: klen_q, ctx: ctx_q, clen: clen_q,
			seq: seq_c, stamp: now_q};
		load_out = 1'b0;
		scan_end = (addr_q == LAST) && !pv_s1;
		clr_en   = pv_s1 && m.clear;
		unique case (state_q)
			rwt_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = rwt_pkg::ST_SCAN;
				end
			end
			rwt_pkg::ST_SCAN: begin
				if (scan_end) begin
					priority if (op_q == rwt_pkg::OP_CHECK && hit_q) begin
						state_d = rwt_pkg::ST_DIFF;
					end else if (op_q == rwt_pkg::OP_ADD) begin
						state_d = rwt_pkg::ST_ADD;
					end else begin
						state_d = rwt_pkg::ST_DONE;
					end
				end
			end
			rwt_pkg::ST_DIFF: begin
				state_d = rwt_pkg::ST_MAG;
			end
			rwt_pkg::ST_MAG: begin
				state_d = rwt_pkg::ST_UPDATE;
			end
			rwt_pkg::ST_UPDATE: begin
				wr_en   = 1'b1;
				state_d = rwt_pkg::ST_DONE;
			end
			rwt_pkg::ST_ADD: begin
				wr_en      = 1'b1;
				set_en     = 1'b1;
				wr_win     = WIN_ONE;
				wr_rec.seq = seq_q;
				priority if (hit_q) begin
					wr_addr = hit_idx_q;
				end else if (empty_seen_q) begin
					wr_addr = empty_idx_q;
				end else begin
					wr_addr = old_idx_q;
				end
				state_d = rwt_pkg::ST_DONE;
			end
			rwt_pkg::ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d  = rwt_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = rwt_pkg::ST_IDLE;
			end
		endcase
	end

	assign in_fire = in_valid && in_ready;

	// State and control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rwt_pkg::ST_IDLE;
			addr_q      <= '0;
			pv_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_fire) begin
				addr_q <= '0;
			end else if (state_q == rwt_pkg::ST_SCAN && addr_q != LAST) begin
				addr_q <= addr_q + CW'(1);
			end
			pv_s1 <= (state_q == rwt_pkg::ST_SCAN) && (addr_q != LAST);
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Request, scan and arithmetic datapath.
	always_ff @(posedge clk) begin
		pidx_s1 <= addr_q[IW-1:0];
		if (in_fire) begin
			op_q         <= rwt_pkg::op_t'(operation);
			seq_q        <= sequence_number;
			klen_q       <= rwt_pkg::clamp_len(key_id_length);
			key_q        <= key_id & rwt_pkg::byte_mask(rwt_pkg::clamp_len(key_id_length));
			clen_q       <= rwt_pkg::clamp_len(context_length);
			ctx_q        <= context_id & rwt_pkg::byte_mask(rwt_pkg::clamp_len(context_length));
			now_q        <= now;
			hit_q        <= 1'b0;
			empty_seen_q <= 1'b0;
			freed_q      <= 1'b0;
			res_acc_q    <= 1'b0;
		end
		if (pv_s1) begin
			if (m.hit && !hit_q) begin
				hit_q     <= 1'b1;
				hit_idx_q <= pidx_s1;
				hit_seq_q <= rd_rec.seq;
				hit_win_q <= rd_win;
			end
			if (!rd_valid && !empty_seen_q) begin
				empty_seen_q <= 1'b1;
				empty_idx_q  <= pidx_s1;
			end
			if (pidx_s1 == '0 || m.older) begin
				old_idx_q   <= pidx_s1;
				old_stamp_q <= rd_rec.stamp;
			end
			if (m.clear) begin
				freed_q <= 1'b1;
			end
		end
		if (state_q == rwt_pkg::ST_SCAN && scan_end) begin
			res_found_q <= (op_q == rwt_pkg::OP_FREE) ? freed_q : hit_q;
		end
		if (state_q == rwt_pkg::ST_DIFF) begin
			diff_q <= {1'b0, hit_seq_q} - {1'b0, seq_q};
		end
		if (state_q == rwt_pkg::ST_MAG) begin
			older_q <= !diff_q[40];
			dist_q  <= diff_q[40] ? (~diff_q[39:0] + 40'd1) : diff_q[39:0];
		end
		if (state_q == rwt_pkg::ST_UPDATE) begin
			res_acc_q <= acc_c;
		end
		if (load_out) begin
			accepted_q <= res_acc_q;
			found_q    <= res_found_q;
		end
	end

	assign out_valid = out_valid_q;
	assign accepted  = accepted_q;
	assign found     = found_q;

`ifndef NO_ASSERTIONS
	// The scan pipeline has drained when the sequencer leaves the scan.
	a_scan_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rwt_pkg::ST_SCAN && state_d != rwt_pkg::ST_SCAN) |-> !pv_s1)
		else $error("scan left with a record still in flight");

	// The table is written only by the update and add steps.
	a_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q == rwt_pkg::ST_UPDATE || state_q == rwt_pkg::ST_ADD))
		else $error("record write outside update or add");

	// A request is never taken twice in a row.
	a_one_request: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !in_ready)
		else $error("request side ready right after a request");

	// Only a check on a known record can be accepted.
	a_accept_cause: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && res_acc_q) |-> (op_q == rwt_pkg::OP_CHECK && hit_q))
		else $error("accepted result without a matching check");
`endif

endmodule
`default_nettype wire

>>> design/rwt_store.sv
`default_nettype none
module rwt_store #(
	parameter int RECORDS     = 16,
	parameter int WINDOW_BITS = 32,
	parameter int IW          = 4
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire [IW-1:0]            rd_addr,
	output rwt_pkg::rec_t           rd_rec_q,
	output logic [WINDOW_BITS-1:0]  rd_win_q,
	output logic                    rd_valid_q,
	input  wire                     wr_en,
	input  wire [IW-1:0]            wr_addr,
	input  rwt_pkg::rec_t           wr_rec,
	input  wire [WINDOW_BITS-1:0]   wr_win,
	input  wire                     set_en,
	input  wire                     clr_en,
	input  wire [IW-1:0]            clr_addr
);

	rwt_pkg::rec_t           rec_mem [RECORDS];
	logic [WINDOW_BITS-1:0]  win_mem [RECORDS];
	logic [RECORDS-1:0]      valid_q;

	// Record memory with one write port and one registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			rec_mem[wr_addr] <= wr_rec;
			win_mem[wr_addr] <= wr_win;
		end
		rd_rec_q <= rec_mem[rd_addr];
		rd_win_q <= win_mem[rd_addr];
	end

	// Valid bits live in flip-flops so that reset empties the table at once.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (clr_en) begin
				valid_q[clr_addr] <= 1'b0;
			end
			if (set_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			rd_valid_q <= valid_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

>>> design/rwt_match.sv
`default_nettype none
module rwt_match (
	input  rwt_pkg::op_t    op,
	input  wire [63:0]      key,
	input  wire [3:0]       klen,
	input  wire [63:0]      ctx,
	input  wire [3:0]       clen,
	input  rwt_pkg::rec_t   rec,
	input  wire             rec_valid,
	input  wire [31:0]      old_stamp,
	output rwt_pkg::match_t m
);

	logic key_eq;
	logic ctx_eq;

	// Comparison of one record against the request: key and context for a hit, key only for a free, stamp for age.
	always_comb begin
		key_eq  = (rec.klen == klen) && (rec.key == key);
		ctx_eq  = (rec.clen == clen) && (rec.ctx == ctx);
		m.hit   = ((op == rwt_pkg::OP_CHECK) || (op == rwt_pkg::OP_ADD)) && rec_valid &&
			(klen != 4'd0) && key_eq && ctx_eq;
		m.clear = (op == rwt_pkg::OP_FREE) && rec_valid && key_eq;
		m.older = rec.stamp < old_stamp;
	end

endmodule
`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

	localparam int RECORDS       = 16;
	localparam int WINDOW_BITS   = 32;
	localparam int CLIENTS       = 20;
	localparam int PHASES        = 7;
	localparam int PHASE_ITEMS   = 240;
	localparam int HOLD_CYCLES   = 300;
	localparam int DRAIN_CYCLES  = 40;
	localparam longint CYCLE_LIMIT = 500000;

	// One request as offered on the input channel.
	typedef struct {
		rwt_pkg::op_t op;
		logic [39:0] seq;
		logic [63:0] key;
		logic [3:0]  klen;
		logic [63:0] ctx;
		logic [3:0]  clen;
		logic [31:0] stamp;
	} request_t;

	typedef struct packed {
		logic accepted;
		logic found;
	} verdict_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  operation = '0;
	logic [39:0] sequence_number = '0;
	logic [63:0] key_id = '0;
	logic [3:0]  key_id_length = '0;
	logic [63:0] context_id = '0;
	logic [3:0]  context_length = '0;
	logic [31:0] now = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        accepted;
	logic        found;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	replay_window_table #(
		.RECORDS(RECORDS),
		.WINDOW_BITS(WINDOW_BITS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.operation(operation),
		.sequence_number(sequence_number),
		.key_id(key_id),
		.key_id_length(key_id_length),
		.context_id(context_id),
		.context_length(context_length),
		.now(now),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.accepted(accepted),
		.found(found),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// Shadow copy of the client table and the forward limit.
	logic        tbl_valid [RECORDS];
	logic [39:0] tbl_seq   [RECORDS];
	logic [31:0] tbl_win   [RECORDS];
	logic [63:0] tbl_key   [RECORDS];
	logic [3:0]  tbl_klen  [RECORDS];
	logic [63:0] tbl_ctx   [RECORDS];
	logic [3:0]  tbl_clen  [RECORDS];
	logic [31:0] tbl_stamp [RECORDS];
	logic [31:0] fwd_limit_model;

	request_t outgoing_requests[$];
	verdict_t expected_verdicts[$];

	// Client pool used to build well-formed traffic.
	logic [63:0] cl_key  [CLIENTS];
	logic [3:0]  cl_klen [CLIENTS];
	logic [63:0] cl_ctx  [CLIENTS];
	logic [3:0]  cl_clen [CLIENTS];
	logic [39:0] cl_seq  [CLIENTS];
	logic [31:0] clock_stamp;

	request_t cur_req;
	request_t seen_req;
	verdict_t want;
	logic     req_fire = 1'b0;
	int       burst_left = 1;
	int       gap_left = 0;
	int       hold_left = 0;
	int       next_hold_at = 150;
	int       pat_age = 0;
	logic [15:0] stall_pat = 16'hFFFF;
	longint   cycle_count = 0;

	int errors = 0;
	int requests_taken = 0;
	int results_seen = 0;
	int fresh_checks = 0;
	int refused_checks = 0;
	int missed_checks = 0;
	int evictions = 0;
	int add_hits = 0;
	int frees_found = 0;
	int limits_used = 0;
	int holds_done = 0;

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [39:0] rand40();
		return {8'($urandom), 32'($urandom)};
	endfunction

	// Lengths beyond eight bytes behave as eight.
	function automatic logic [3:0] clamp_bytes(input logic [3:0] n);
		return (n > 4'd8) ? 4'd8 : n;
	endfunction

	// Keeps the leading nbytes bytes of a left-aligned byte string.
	function automatic logic [63:0] lead_mask(input logic [3:0] nbytes);
		if (nbytes == 4'd0)
			return 64'd0;
		return ~64'd0 << (64 - 8 * int'(nbytes));
	endfunction

	function automatic logic [31:0] tick();
		clock_stamp += 32'($urandom_range(0, 3));
		return clock_stamp;
	endfunction

	function automatic void wipe_record(input int i);
		tbl_valid[i] = 1'b0;
		tbl_seq[i]   = '0;
		tbl_win[i]   = '0;
		tbl_key[i]   = '0;
		tbl_klen[i]  = '0;
		tbl_ctx[i]   = '0;
		tbl_clen[i]  = '0;
		tbl_stamp[i] = '0;
	endfunction

	// Index of the valid record holding this key and context, or RECORDS.
	function automatic int lookup_record(input logic [63:0] key, input logic [3:0] klen,
			input logic [63:0] ctx, input logic [3:0] clen);
		if (klen == 4'd0)
			return RECORDS;
		for (int i = 0; i < RECORDS; i++) begin
			if (tbl_valid[i] && tbl_klen[i] == klen && tbl_key[i] == key &&
					tbl_clen[i] == clen && tbl_ctx[i] == ctx)
				return i;
		end
		return RECORDS;
	endfunction

	// First free record, else the first one with the oldest stamp is evicted.
	function automatic int claim_record();
		int oldest;
		oldest = 0;
		for (int i = 0; i < RECORDS; i++) begin
			if (!tbl_valid[i])
				return i;
		end
		for (int i = 1; i < RECORDS; i++) begin
			if (tbl_stamp[i] < tbl_stamp[oldest])
				oldest = i;
		end
		wipe_record(oldest);
		evictions++;
		return oldest;
	endfunction

	// Applies one request to the shadow table and returns the verdict it earns.
	function automatic verdict_t screen_request(input request_t r);
		verdict_t    v;
		logic [3:0]  klen;
		logic [3:0]  clen;
		logic [63:0] key;
		logic [63:0] ctx;
		logic [39:0] span;
		int          idx;
		v    = '0;
		klen = clamp_bytes(r.klen);
		clen = clamp_bytes(r.clen);
		key  = r.key & lead_mask(klen);
		ctx  = r.ctx & lead_mask(clen);
		case (r.op)
			rwt_pkg::OP_CHECK: begin
				idx = lookup_record(key, klen, ctx, clen);
				if (idx < RECORDS) begin
					v.found = 1'b1;
					tbl_stamp[idx] = r.stamp;
					if (r.seq <= tbl_seq[idx]) begin
						// Older or equal number: accept once per window bit.
						span = tbl_seq[idx] - r.seq;
						if (span < WINDOW_BITS &&
								(tbl_win[idx] & (32'd1 << span)) == 32'd0) begin
							tbl_win[idx] |= 32'd1 << span;
							v.accepted = 1'b1;
						end
					end else begin
						// Newer number: slide the window if the jump is allowed.
						span = r.seq - tbl_seq[idx];
						if (span <= {8'd0, fwd_limit_model}) begin
							tbl_win[idx] = (span < WINDOW_BITS) ?
								((tbl_win[idx] << span) | 32'd1) : 32'd1;
							tbl_seq[idx] = r.seq;
							v.accepted = 1'b1;
						end
					end
					if (v.accepted)
						fresh_checks++;
					else
						refused_checks++;
				end else begin
					missed_checks++;
				end
			end
			rwt_pkg::OP_ADD: begin
				idx = lookup_record(key, klen, ctx, clen);
				if (idx < RECORDS) begin
					v.found = 1'b1;
					add_hits++;
				end else begin
					idx = claim_record();
					tbl_key[idx]   = key;
					tbl_klen[idx]  = klen;
					tbl_ctx[idx]   = ctx;
					tbl_clen[idx]  = clen;
					tbl_valid[idx] = 1'b1;
				end
				tbl_seq[idx]   = r.seq;
				tbl_win[idx]   = 32'd1;
				tbl_stamp[idx] = r.stamp;
			end
			rwt_pkg::OP_FREE: begin
				for (int i = 0; i < RECORDS; i++) begin
					if (tbl_klen[i] == klen && tbl_key[i] == key) begin
						if (tbl_valid[i])
							v.found = 1'b1;
						wipe_record(i);
					end
				end
				if (v.found)
					frees_found++;
			end
			default: ;
		endcase
		return v;
	endfunction

	function automatic void queue_request(input rwt_pkg::op_t op, input logic [39:0] seq,
			input logic [63:0] key, input logic [3:0] klen,
			input logic [63:0] ctx, input logic [3:0] clen);
		request_t r;
		r.op    = op;
		r.seq   = seq;
		r.key   = key;
		r.klen  = klen;
		r.ctx   = ctx;
		r.clen  = clen;
		r.stamp = tick();
		outgoing_requests.push_back(r);
	endfunction

	// Mostly checks and adds on known clients, with some noise requests.
	task automatic queue_random_phase(input int count);
		request_t    r;
		int          c;
		int          pick;
		int          sel;
		logic [39:0] base;
		logic [39:0] step;
		for (int n = 0; n < count; n++) begin
			c      = $urandom_range(0, CLIENTS - 1);
			pick   = $urandom_range(0, 99);
			r.op   = rwt_pkg::OP_CHECK;
			r.key  = cl_key[c];
			r.klen = cl_klen[c];
			r.ctx  = cl_ctx[c];
			r.clen = cl_clen[c];
			r.seq  = cl_seq[c];
			r.stamp = tick();
			// Junk past the stated lengths must not affect matching.
			if ($urandom_range(0, 1)) begin
				r.key |= rand64() & ~lead_mask(clamp_bytes(r.klen));
				r.ctx |= rand64() & ~lead_mask(clamp_bytes(r.clen));
			end
			if (pick < 55) begin
				base = cl_seq[c];
				sel  = $urandom_range(0, 99);
				if (sel < 35)
					r.seq = base + 40'($urandom_range(1, 3));
				else if (sel < 55)
					r.seq = base - 40'($urandom_range(0, 34));
				else if (sel < 65)
					r.seq = base;
				else if (sel < 77)
					r.seq = base + {8'd0, fwd_limit_model} + 40'($urandom_range(0, 2)) - 40'd1;
				else if (sel < 85)
					r.seq = base + 40'($urandom_range(28, 36));
				else if (sel < 90)
					r.seq = base - 40'($urandom_range(30, 34));
				else
					r.seq = rand40();
				step = r.seq - base;
				if (step != 40'd0 && step <= {8'd0, fwd_limit_model})
					cl_seq[c] = r.seq;
			end else if (pick < 72) begin
				r.op  = rwt_pkg::OP_ADD;
				r.seq = $urandom_range(0, 1) ? rand40() : cl_seq[c] + 40'($urandom_range(0, 5));
				cl_seq[c] = r.seq;
			end else if (pick < 78) begin
				r.op  = rwt_pkg::OP_FREE;
				r.seq = rand40();
			end else if (pick < 90) begin
				r.op   = rwt_pkg::op_t'($urandom_range(0, 3));
				r.seq  = rand40();
				r.key  = rand64();
				r.klen = 4'($urandom_range(0, 15));
				r.ctx  = rand64();
				r.clen = 4'($urandom_range(0, 15));
			end else if (pick < 94) begin
				r.op   = rwt_pkg::op_t'($urandom_range(0, 2));
				r.seq  = rand40();
				r.key  = rand64();
				r.klen = 4'd0;
			end else begin
				r.op  = rwt_pkg::OP_NONE;
				r.seq = rand40();
			end
			outgoing_requests.push_back(r);
		end
	endtask

	// One register access: setup cycle, then access cycle.
	task automatic apb_access(input logic write, input logic [31:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= write;
		paddr   <= {rwt_pkg::REG_FWD_LIMIT, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (write) begin
			fwd_limit_model = value;
			limits_used++;
		end else if (prdata !== fwd_limit_model) begin
			errors++;
			if (errors <= 10)
				$display("Limit readback mismatch: expected %0d, got %0d",
					fwd_limit_model, prdata);
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Returns once every queued request has been taken and answered.
	task automatic wait_idle();
		forever begin
			@(posedge clk);
			#1;
			if (outgoing_requests.size() == 0 && !in_valid && expected_verdicts.size() == 0)
				break;
		end
	endtask

	// Request driver: bursts of random length separated by random gaps.
	always @(negedge clk) begin
		if (!in_valid || req_fire) begin
			if (gap_left > 0 || outgoing_requests.size() == 0) begin
				in_valid <= 1'b0;
				if (gap_left > 0)
					gap_left--;
			end else begin
				cur_req = outgoing_requests.pop_front();
				in_valid        <= 1'b1;
				operation       <= cur_req.op;
				sequence_number <= cur_req.seq;
				key_id          <= cur_req.key;
				key_id_length   <= cur_req.klen;
				context_id      <= cur_req.ctx;
				context_length  <= cur_req.clen;
				now             <= cur_req.stamp;
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 24);
					gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
				end else begin
					burst_left--;
				end
			end
		end
	end

	// Result receiver: rotating stall pattern, plus long hold-offs now and then.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left--;
		end else if (results_seen >= next_hold_at) begin
			out_ready <= 1'b0;
			hold_left = HOLD_CYCLES - 1;
			next_hold_at += 850;
			holds_done++;
		end else begin
			out_ready <= stall_pat[0];
			stall_pat = {stall_pat[0], stall_pat[15:1]};
			pat_age++;
			if (pat_age == 64) begin
				pat_age   = 0;
				stall_pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0101);
			end
		end
	end

	// Monitor: predict on each taken request, check each delivered result.
	always @(posedge clk) begin
		req_fire <= in_valid && in_ready;
		if (arst_n && in_valid && in_ready) begin
			seen_req.op    = rwt_pkg::op_t'(operation);
			seen_req.seq   = sequence_number;
			seen_req.key   = key_id;
			seen_req.klen  = key_id_length;
			seen_req.ctx   = context_id;
			seen_req.clen  = context_length;
			seen_req.stamp = now;
			expected_verdicts.push_back(screen_request(seen_req));
			requests_taken++;
		end
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (expected_verdicts.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("Unexpected result at cycle %0d: accepted=%0b found=%0b",
						cycle_count, accepted, found);
			end else begin
				want = expected_verdicts.pop_front();
				if (accepted !== want.accepted || found !== want.found) begin
					errors++;
					if (errors <= 10)
						$display("Mismatch at cycle %0d: expected accepted=%0b found=%0b, got accepted=%0b found=%0b",
							cycle_count, want.accepted, want.found, accepted, found);
				end
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d results outstanding",
				cycle_count, expected_verdicts.size());
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		logic [63:0] base_key [8];
		logic [31:0] limit_plan [PHASES];
		logic [63:0] key_a;
		logic [63:0] key_b;
		logic [63:0] ctx_b;

		for (int i = 0; i < RECORDS; i++)
			wipe_record(i);
		fwd_limit_model = rwt_pkg::FWD_LIMIT_RESET;
		clock_stamp = 32'd10;

		// Client pool: shared key prefixes so lengths and contexts tell them apart.
		for (int b = 0; b < 8; b++)
			base_key[b] = rand64();
		for (int c = 0; c < CLIENTS; c++) begin
			cl_klen[c] = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15)) :
				4'($urandom_range(1, 8));
			cl_key[c]  = base_key[c % 8] & lead_mask(clamp_bytes(cl_klen[c]));
			cl_clen[c] = ($urandom_range(0, 4) < 2) ? 4'd0 : 4'($urandom_range(1, 10));
			cl_ctx[c]  = rand64() & lead_mask(clamp_bytes(cl_clen[c]));
			cl_seq[c]  = rand40();
		end

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// The limit register must come out of reset at its default.
		apb_access(1'b0, 32'd0);

		// Directed requests: window edges, replays, lengths, empty keys, frees.
		key_a = 64'hA1B2_C3D4_E5F6_0718;
		key_b = 64'hDEAD_BEFF_FFFF_FFFF;
		ctx_b = 64'h0102_0304_0506_0708;
		queue_request(rwt_pkg::OP_CHECK, 40'd100, key_a, 4'd8, 64'd0, 4'd0);
		queue_request(rwt_pkg::OP_ADD,   40'd100, key_a, 4'd8, 64'd0, 4'd0);
		queue_request(rwt_pkg::OP_CHECK, 40'd100, key_a, 4'd8, 64'd0, 4'd0);
		queue_request(rwt_pkg::OP_CHECK, 40'd99,  key_a, 4'd8, 64'd0, 4'd0);
		queue_request(rwt_pkg::OP_CHECK, 40'd99,  key_a, 4'd8, 64'd0, 4'd0);
		queue_request(rwt_pkg::OP_CHECK, 40'd69,  key_a, 4'd8, 64'd0, 4'd0);
		queue_request(rwt_pkg::OP_CHECK, 40'd68,  key_a, 4'd8, 64'd0, 4'd0);
		queue_request(rwt_pkg::OP_CHECK, 40'd132, key_a, 4'd8, 64'd0, 4'd0);
		queue_request(rwt_pkg::OP_CHECK, 40'd165, key_a, 4'd8, 64'd0, 4'd0);
		queue_request(rwt_pkg::OP_CHECK, 40'd164, key_a, 4'd8, 64'd0, 4'd0);
		queue_request(rwt_pkg::OP_ADD,   40'hFF_FFFF_FFFF, key_a, 4'd8, 64'd0, 4'd0);
		queue_request(rwt_pkg::OP_CHECK, 40'd0,   key_a, 4'd8, 64'd0, 4'd0);
		queue_request(rwt_pkg::OP_CHECK, 40'hFF_FFFF_FFFE, key_a, 4'd8, 64'd0, 4'd0);
		queue_request(rwt_pkg::OP_ADD,   40'd0,   key_b, 4'd3, ctx_b, 4'd15);
		queue_request(rwt_pkg::OP_CHECK, 40'd1,   64'hDEAD_BE00_0000_0000, 4'd3, ctx_b, 4'd8);
		queue_request(rwt_pkg::OP_CHECK, 40'd2,   key_b, 4'd3, ctx_b, 4'd0);
		queue_request(rwt_pkg::OP_ADD,   40'd5,   64'd0, 4'd0, 64'd0, 4'd0);
		queue_request(rwt_pkg::OP_CHECK, 40'd6,   64'd0, 4'd0, 64'd0, 4'd0);
		queue_request(rwt_pkg::OP_FREE,  40'd0,   64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 64'd0, 4'd0);
		queue_request(rwt_pkg::OP_NONE,  40'hFF_FFFF_FFFF, ~64'd0, 4'hF, ~64'd0, 4'hF);
		queue_request(rwt_pkg::OP_ADD,   40'd7,   key_a, 4'd8, ctx_b, 4'd4);
		queue_request(rwt_pkg::OP_FREE,  40'd0,   key_a, 4'd8, 64'd0, 4'd0);
		queue_request(rwt_pkg::OP_CHECK, 40'd8,   key_a, 4'd8, 64'd0, 4'd0);
		queue_request(rwt_pkg::OP_FREE,  40'd0,   key_a, 4'd8, 64'd0, 4'd0);
		queue_request(rwt_pkg::OP_CHECK, 40'hFF_FFFF_FFFF, ~64'd0, 4'hF, ~64'd0, 4'hF);
		wait_idle();

		// Random phases, each under its own forward limit.
		limit_plan = '{32'd0, 32'd1, 32'd31, 32'd33, 32'hFFFF_FFFF, 32'd0, 32'd32};
		limit_plan[5] = $urandom_range(2, 5000);
		for (int p = 0; p < PHASES; p++) begin
			apb_access(1'b1, limit_plan[p]);
			apb_access(1'b0, 32'd0);
			clock_stamp = (p == PHASES - 1) ? 32'hFFFF_FF80 : $urandom;
			queue_random_phase(PHASE_ITEMS);
			wait_idle();
		end

		// Let any stray result show up before the verdict.
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_verdicts.size() != 0) begin
			errors++;
			$display("%0d expected results never arrived", expected_verdicts.size());
		end

		$display("Covered %0d requests: %0d fresh checks, %0d refused, %0d missed, %0d evictions",
			requests_taken, fresh_checks, refused_checks, missed_checks, evictions);
		$display("Also %0d repeated adds, %0d clearing frees, %0d limit writes, %0d long stalls",
			add_hits, frees_found, limits_used, holds_done);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
